>>> hw/rtl/eic_pkg.sv
package eic_pkg;

    // Field and register widths
    localparam int COORD_W   = 16;
    localparam int COEF_W    = 32;
    localparam int THRESH_W  = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_CNT_W = 16;

    localparam int COORD_FRAC_BITS = 4;
    localparam int COUNT_WIDTH     = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(50);

    // Shared multiplier works on 32-bit limbs into a 160-bit accumulator
    localparam int LIMB_W     = 32;
    localparam int LIMB_LOG   = $clog2(LIMB_W);
    localparam int LIMB_SEL_W = 2;
    localparam int SHIFT_W    = 3;
    localparam int OPND_W     = LIMB_W << LIMB_SEL_W;
    localparam int ACC_W      = 160;

    // Exact magnitudes of the intermediate values
    localparam int LINE_W = COEF_W + COORD_W + 2;    // a, b, c, a', b'
    localparam int RES_W  = LINE_W + COORD_W + 2;    // r
    localparam int R2_W   = 2 * RES_W;               // r^2
    localparam int SUM_W  = 2 * LINE_W + 1;          // a^2 + b^2
    localparam int K_W    = THRESH_W + 2 * COORD_FRAC_BITS;

    localparam int NUM_COEF   = 9;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);

    localparam int UOP_COUNT = 54;
    localparam int STEP_W    = $clog2(UOP_COUNT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR0  = 3'd0,
        CFG_PAIR1  = 3'd1,
        CFG_PAIR2  = 3'd2,
        CFG_PAIR3  = 3'd3,
        CFG_LAST   = 3'd4,
        CFG_THRESH = 3'd5
    } cfg_reg_t;

    // Operand sources; the coefficient entries come first, in order
    typedef enum logic [4:0] {
        SRC_F0, SRC_F1, SRC_F2, SRC_F3, SRC_F4, SRC_F5, SRC_F6, SRC_F7, SRC_F8,
        SRC_X1, SRC_Y1, SRC_X2, SRC_Y2, SRC_ONE,
        SRC_A, SRC_B, SRC_C, SRC_TA, SRC_TB,
        SRC_R, SRC_S, SRC_K
    } src_t;

    // Where a finished accumulation goes
    typedef enum logic [3:0] {
        DST_A, DST_B, DST_C, DST_TA, DST_TB,
        DST_R, DST_R2, DST_S, DST_OK1, DST_OK2
    } dst_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef struct packed {
        src_t                  a_src;
        logic [LIMB_SEL_W-1:0] a_limb;
        src_t                  b_src;
        logic [LIMB_SEL_W-1:0] b_limb;
        logic                  last;
        dst_t                  dst;
    } uop_t;

    typedef struct packed {
        logic issue;
        uop_t uop;
        logic store;
        dst_t dst;
    } ctrl_t;

    function automatic uop_t mk(input src_t a, input logic [LIMB_SEL_W-1:0] al,
                                input src_t b, input logic [LIMB_SEL_W-1:0] bl,
                                input logic l, input dst_t d);
        uop_t u;
        u.a_src  = a;
        u.a_limb = al;
        u.b_src  = b;
        u.b_limb = bl;
        u.last   = l;
        u.dst    = d;
        return u;
    endfunction

    // Product schedule; shift of each product is a_limb + b_limb limbs
    localparam uop_t UCODE [UOP_COUNT] = '{
        // l = F * p1
        mk(SRC_F0, 2'd0, SRC_X1, 2'd0, 1'b0, DST_A),
        mk(SRC_F1, 2'd0, SRC_Y1, 2'd0, 1'b0, DST_A),
        mk(SRC_F2, 2'd0, SRC_ONE, 2'd0, 1'b1, DST_A),
        mk(SRC_F3, 2'd0, SRC_X1, 2'd0, 1'b0, DST_B),
        mk(SRC_F4, 2'd0, SRC_Y1, 2'd0, 1'b0, DST_B),
        mk(SRC_F5, 2'd0, SRC_ONE, 2'd0, 1'b1, DST_B),
        mk(SRC_F6, 2'd0, SRC_X1, 2'd0, 1'b0, DST_C),
        mk(SRC_F7, 2'd0, SRC_Y1, 2'd0, 1'b0, DST_C),
        mk(SRC_F8, 2'd0, SRC_ONE, 2'd0, 1'b1, DST_C),
        // first two entries of F^T * p2
        mk(SRC_F0, 2'd0, SRC_X2, 2'd0, 1'b0, DST_TA),
        mk(SRC_F3, 2'd0, SRC_Y2, 2'd0, 1'b0, DST_TA),
        mk(SRC_F6, 2'd0, SRC_ONE, 2'd0, 1'b1, DST_TA),
        mk(SRC_F1, 2'd0, SRC_X2, 2'd0, 1'b0, DST_TB),
        mk(SRC_F4, 2'd0, SRC_Y2, 2'd0, 1'b0, DST_TB),
        mk(SRC_F7, 2'd0, SRC_ONE, 2'd0, 1'b1, DST_TB),
        // r = l . p2
        mk(SRC_A, 2'd0, SRC_X2, 2'd0, 1'b0, DST_R),
        mk(SRC_A, 2'd1, SRC_X2, 2'd0, 1'b0, DST_R),
        mk(SRC_B, 2'd0, SRC_Y2, 2'd0, 1'b0, DST_R),
        mk(SRC_B, 2'd1, SRC_Y2, 2'd0, 1'b0, DST_R),
        mk(SRC_C, 2'd0, SRC_ONE, 2'd0, 1'b0, DST_R),
        mk(SRC_C, 2'd1, SRC_ONE, 2'd0, 1'b1, DST_R),
        // r^2
        mk(SRC_R, 2'd0, SRC_R, 2'd0, 1'b0, DST_R2),
        mk(SRC_R, 2'd0, SRC_R, 2'd1, 1'b0, DST_R2),
        mk(SRC_R, 2'd0, SRC_R, 2'd2, 1'b0, DST_R2),
        mk(SRC_R, 2'd1, SRC_R, 2'd0, 1'b0, DST_R2),
        mk(SRC_R, 2'd1, SRC_R, 2'd1, 1'b0, DST_R2),
        mk(SRC_R, 2'd1, SRC_R, 2'd2, 1'b0, DST_R2),
        mk(SRC_R, 2'd2, SRC_R, 2'd0, 1'b0, DST_R2),
        mk(SRC_R, 2'd2, SRC_R, 2'd1, 1'b0, DST_R2),
        mk(SRC_R, 2'd2, SRC_R, 2'd2, 1'b1, DST_R2),
        // a^2 + b^2
        mk(SRC_A, 2'd0, SRC_A, 2'd0, 1'b0, DST_S),
        mk(SRC_A, 2'd0, SRC_A, 2'd1, 1'b0, DST_S),
        mk(SRC_A, 2'd1, SRC_A, 2'd0, 1'b0, DST_S),
        mk(SRC_A, 2'd1, SRC_A, 2'd1, 1'b0, DST_S),
        mk(SRC_B, 2'd0, SRC_B, 2'd0, 1'b0, DST_S),
        mk(SRC_B, 2'd0, SRC_B, 2'd1, 1'b0, DST_S),
        mk(SRC_B, 2'd1, SRC_B, 2'd0, 1'b0, DST_S),
        mk(SRC_B, 2'd1, SRC_B, 2'd1, 1'b1, DST_S),
        // K * (a^2 + b^2), compared against r^2
        mk(SRC_S, 2'd0, SRC_K, 2'd0, 1'b0, DST_OK1),
        mk(SRC_S, 2'd1, SRC_K, 2'd0, 1'b0, DST_OK1),
        mk(SRC_S, 2'd2, SRC_K, 2'd0, 1'b0, DST_OK1),
        mk(SRC_S, 2'd3, SRC_K, 2'd0, 1'b1, DST_OK1),
        // a'^2 + b'^2
        mk(SRC_TA, 2'd0, SRC_TA, 2'd0, 1'b0, DST_S),
        mk(SRC_TA, 2'd0, SRC_TA, 2'd1, 1'b0, DST_S),
        mk(SRC_TA, 2'd1, SRC_TA, 2'd0, 1'b0, DST_S),
        mk(SRC_TA, 2'd1, SRC_TA, 2'd1, 1'b0, DST_S),
        mk(SRC_TB, 2'd0, SRC_TB, 2'd0, 1'b0, DST_S),
        mk(SRC_TB, 2'd0, SRC_TB, 2'd1, 1'b0, DST_S),
        mk(SRC_TB, 2'd1, SRC_TB, 2'd0, 1'b0, DST_S),
        mk(SRC_TB, 2'd1, SRC_TB, 2'd1, 1'b1, DST_S),
        // K * (a'^2 + b'^2)
        mk(SRC_S, 2'd0, SRC_K, 2'd0, 1'b0, DST_OK2),
        mk(SRC_S, 2'd1, SRC_K, 2'd0, 1'b0, DST_OK2),
        mk(SRC_S, 2'd2, SRC_K, 2'd0, 1'b0, DST_OK2),
        mk(SRC_S, 2'd3, SRC_K, 2'd0, 1'b1, DST_OK2)
    };

endpackage

>>> hw/rtl/eic_mac.sv
// Shared 32x32 multiplier, registered product, shifted signed accumulate.
module eic_mac (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  eic_pkg::ctrl_t             ctrl_i,
    input  logic [eic_pkg::LIMB_W-1:0] opa,
    input  logic [eic_pkg::LIMB_W-1:0] opb,
    input  logic                       prod_neg,
    output logic [eic_pkg::ACC_W-1:0]  acc
);
    localparam int LW  = eic_pkg::LIMB_W;
    localparam int AW  = eic_pkg::ACC_W;
    localparam int SW  = eic_pkg::SHIFT_W;
    localparam int LLG = eic_pkg::LIMB_LOG;

    logic [2*LW-1:0] prod_reg;
    logic            prod_neg_reg;
    logic [SW-1:0]   prod_sh_reg;
    logic            prod_v_reg;
    logic [AW-1:0]   acc_reg;
    logic [AW-1:0]   acc_next;
    logic [AW-1:0]   term;
    logic [SW+LLG-1:0] sh_bits;

    always_ff @(posedge aclk) begin
        prod_reg     <= (2*LW)'(opa) * (2*LW)'(opb);
        prod_neg_reg <= prod_neg;
        prod_sh_reg  <= SW'(ctrl_i.uop.a_limb) + SW'(ctrl_i.uop.b_limb);
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= ctrl_i.issue;
        end
    end

    assign sh_bits = {prod_sh_reg, LLG'(0)};
    assign term    = AW'(prod_reg) << sh_bits;

    always_comb begin
        if (prod_neg_reg) begin
            acc_next = acc_reg - term;
        end else begin
            acc_next = acc_reg + term;
        end
    end

    // cleared on every store, so each group starts from zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl_i.store) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> hw/rtl/eic_opnd.sv
// Operand store: intermediate magnitudes and signs, limb select for the multiplier.
module eic_opnd (
    input  logic                                         aclk,
    input  eic_pkg::ctrl_t                               ctrl_i,
    input  logic [eic_pkg::ACC_W-1:0]                    acc,
    input  logic [eic_pkg::NUM_COEF-1:0][eic_pkg::COEF_W-1:0] coef,
    input  logic [eic_pkg::THRESH_W-1:0]                 thresh,
    input  logic [eic_pkg::COORD_W-1:0]                  x1,
    input  logic [eic_pkg::COORD_W-1:0]                  y1,
    input  logic [eic_pkg::COORD_W-1:0]                  x2,
    input  logic [eic_pkg::COORD_W-1:0]                  y2,
    output logic [eic_pkg::LIMB_W-1:0]                   opa,
    output logic [eic_pkg::LIMB_W-1:0]                   opb,
    output logic                                         prod_neg,
    output logic                                         ok1,
    output logic                                         ok2
);
    localparam int LW  = eic_pkg::LIMB_W;
    localparam int OW  = eic_pkg::OPND_W;
    localparam int AW  = eic_pkg::ACC_W;
    localparam int CW  = eic_pkg::COEF_W;
    localparam int LNW = eic_pkg::LINE_W;
    localparam int RW  = eic_pkg::RES_W;
    localparam int R2W = eic_pkg::R2_W;
    localparam int SMW = eic_pkg::SUM_W;
    localparam int KW  = eic_pkg::K_W;
    localparam int FB  = eic_pkg::COORD_FRAC_BITS;
    localparam int CIW = eic_pkg::COEF_IDX_W;
    localparam int LLG = eic_pkg::LIMB_LOG;

    typedef struct packed {
        logic          neg;
        logic [OW-1:0] mag;
    } opnd_t;

    logic [LNW-1:0] mag_a_reg, mag_b_reg, mag_c_reg, mag_ta_reg, mag_tb_reg;
    logic           sgn_a_reg, sgn_b_reg, sgn_c_reg, sgn_ta_reg, sgn_tb_reg;
    logic [RW-1:0]  mag_r_reg;
    logic [R2W-1:0] r2_reg;
    logic [SMW-1:0] sum_reg;
    logic           ok1_reg, ok2_reg;
    logic [KW-1:0]  k_val;
    opnd_t          pa, pb;

    function automatic logic [CW-1:0] fmag(input logic [CW-1:0] f);
        return f[CW-1] ? CW'(~f + 1'b1) : f;
    endfunction

    function automatic logic [LNW-1:0] line_abs(input logic [AW-1:0] v);
        logic [LNW-1:0] lo;
        lo = v[LNW-1:0];
        return v[AW-1] ? LNW'(~lo + 1'b1) : lo;
    endfunction

    function automatic logic [RW-1:0] res_abs(input logic [AW-1:0] v);
        logic [RW-1:0] lo;
        lo = v[RW-1:0];
        return v[AW-1] ? RW'(~lo + 1'b1) : lo;
    endfunction

    assign k_val = {thresh, (2*FB)'(0)};

    function automatic opnd_t pick(input eic_pkg::src_t s);
        opnd_t          o;
        logic [CIW-1:0] idx;
        o   = '0;
        idx = CIW'(s);
        if (s <= eic_pkg::SRC_F8) begin
            o.neg = coef[idx][CW-1];
            o.mag = OW'(fmag(coef[idx]));
        end else begin
            unique case (s)
                eic_pkg::SRC_X1:  o.mag = OW'(x1);
                eic_pkg::SRC_Y1:  o.mag = OW'(y1);
                eic_pkg::SRC_X2:  o.mag = OW'(x2);
                eic_pkg::SRC_Y2:  o.mag = OW'(y2);
                eic_pkg::SRC_ONE: o.mag = OW'(1) << FB;
                eic_pkg::SRC_A:   o = '{neg: sgn_a_reg, mag: OW'(mag_a_reg)};
                eic_pkg::SRC_B:   o = '{neg: sgn_b_reg, mag: OW'(mag_b_reg)};
                eic_pkg::SRC_C:   o = '{neg: sgn_c_reg, mag: OW'(mag_c_reg)};
                eic_pkg::SRC_TA:  o = '{neg: sgn_ta_reg, mag: OW'(mag_ta_reg)};
                eic_pkg::SRC_TB:  o = '{neg: sgn_tb_reg, mag: OW'(mag_tb_reg)};
                eic_pkg::SRC_R:   o.mag = OW'(mag_r_reg);
                eic_pkg::SRC_S:   o.mag = OW'(sum_reg);
                eic_pkg::SRC_K:   o.mag = OW'(k_val);
                default:          o = '0;
            endcase
        end
        return o;
    endfunction

    always_comb begin
        pa = pick(ctrl_i.uop.a_src);
        pb = pick(ctrl_i.uop.b_src);
    end

    // squares pick the same sign twice, so r^2 and the sums come out positive
    assign opa      = pa.mag[{ctrl_i.uop.a_limb, LLG'(0)} +: LW];
    assign opb      = pb.mag[{ctrl_i.uop.b_limb, LLG'(0)} +: LW];
    assign prod_neg = pa.neg ^ pb.neg;

    always_ff @(posedge aclk) begin
        if (ctrl_i.store) begin
            case (ctrl_i.dst)
                eic_pkg::DST_A: begin
                    mag_a_reg <= line_abs(acc);
                    sgn_a_reg <= acc[AW-1];
                end
                eic_pkg::DST_B: begin
                    mag_b_reg <= line_abs(acc);
                    sgn_b_reg <= acc[AW-1];
                end
                eic_pkg::DST_C: begin
                    mag_c_reg <= line_abs(acc);
                    sgn_c_reg <= acc[AW-1];
                end
                eic_pkg::DST_TA: begin
                    mag_ta_reg <= line_abs(acc);
                    sgn_ta_reg <= acc[AW-1];
                end
                eic_pkg::DST_TB: begin
                    mag_tb_reg <= line_abs(acc);
                    sgn_tb_reg <= acc[AW-1];
                end
                eic_pkg::DST_R:   mag_r_reg <= res_abs(acc);
                eic_pkg::DST_R2:  r2_reg    <= acc[R2W-1:0];
                eic_pkg::DST_S:   sum_reg   <= acc[SMW-1:0];
                eic_pkg::DST_OK1: ok1_reg   <= (AW'(r2_reg) <= acc);
                eic_pkg::DST_OK2: ok2_reg   <= (AW'(r2_reg) <= acc);
                default: ;
            endcase
        end
    end

    assign ok1 = ok1_reg;
    assign ok2 = ok2_reg;

endmodule

>>> hw/rtl/eic_ctrl.sv
// Sequencer: walks the product schedule, idling after each group while its result is stored.
module eic_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic           out_free,
    output logic           ready,
    output logic           load,
    output eic_pkg::ctrl_t ctrl_o
);
    localparam int STW = eic_pkg::STEP_W;

    eic_pkg::state_t state_reg, state_next;
    logic [STW-1:0]  step_reg, step_next;
    logic [1:0]      wait_reg, wait_next;
    logic            all_reg, all_next;
    logic            st1_v_reg, st2_v_reg;
    eic_pkg::dst_t   st1_dst_reg, st2_dst_reg;
    logic            issue;
    eic_pkg::uop_t   uop;

    assign uop   = eic_pkg::UCODE[step_reg];
    assign issue = (state_reg == eic_pkg::ST_RUN) && (wait_reg == 2'd0) && !all_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            eic_pkg::ST_IDLE: if (start) state_next = eic_pkg::ST_RUN;
            eic_pkg::ST_RUN: begin
                if (st2_v_reg && st2_dst_reg == eic_pkg::DST_OK2) begin
                    state_next = eic_pkg::ST_FIN;
                end
            end
            eic_pkg::ST_FIN:  if (out_free) state_next = eic_pkg::ST_IDLE;
            default:          state_next = eic_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ready         = (state_reg == eic_pkg::ST_IDLE);
        load          = (state_reg == eic_pkg::ST_FIN) && out_free;
        ctrl_o.issue  = issue;
        ctrl_o.uop    = uop;
        ctrl_o.store  = st2_v_reg;
        ctrl_o.dst    = st2_dst_reg;
    end

    always_comb begin
        step_next = step_reg;
        all_next  = all_reg;
        wait_next = (wait_reg != 2'd0) ? wait_reg - 2'd1 : 2'd0;
        if (start) begin
            step_next = '0;
            all_next  = 1'b0;
            wait_next = 2'd0;
        end else if (issue) begin
            if (step_reg == STW'(eic_pkg::UOP_COUNT - 1)) begin
                step_next = '0;
                all_next  = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
            if (uop.last) wait_next = 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        st1_dst_reg <= uop.dst;
        st2_dst_reg <= st1_dst_reg;
        if (!aresetn) begin
            state_reg <= eic_pkg::ST_IDLE;
            step_reg  <= '0;
            wait_reg  <= 2'd0;
            all_reg   <= 1'b1;
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            all_reg   <= all_next;
            st1_v_reg <= issue && uop.last;
            st2_v_reg <= st1_v_reg;
        end
    end

    a_store_no_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_o.store |-> !issue)
        else $error("product issued in a store cycle");

    a_group_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && uop.last) |-> ##2 ctrl_o.store)
        else $error("group end not followed by store two cycles later");

    a_fin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eic_pkg::ST_FIN) |-> (all_reg && wait_reg == 2'd0))
        else $error("result stage reached with schedule still running");

endmodule

>>> hw/rtl/epipolar_inlier_check.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------
// config   | cfg_we             | cfg_addr[2:0], cfg_wdata[63:0]
// s_ (in)  | s_valid / s_ready  | s_x_first, s_y_first, s_x_second,
//          |                    | s_y_second, s_set_start
// m_ (out) | m_valid / m_ready  | m_is_inlier, m_inliers_so_far
//
// Schedule: from one accepted transaction to the next while the output is
//   drained, 54 limb products run through the single 32x32 multiplier, with
//   the block idle after each of the 11 product groups while a group result
//   is stored; then the output is loaded and the next transaction accepted.
// Reset: aresetn synchronous, active low; matrix clears to zero, threshold to 50,
//   tally to zero.
// Stalls: s_ready is high only while idle; a finished result waits in the
//   output register, and a new match is taken while it waits. The block holds
//   before its result stage only if the previous result has not been taken.
module epipolar_inlier_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [eic_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [eic_pkg::CFG_W-1:0]           cfg_wdata,
    // match input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [eic_pkg::COORD_W-1:0]         s_x_first,
    input  logic [eic_pkg::COORD_W-1:0]         s_y_first,
    input  logic [eic_pkg::COORD_W-1:0]         s_x_second,
    input  logic [eic_pkg::COORD_W-1:0]         s_y_second,
    input  logic                                s_set_start,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_inlier,
    output logic [eic_pkg::OUT_CNT_W-1:0]       m_inliers_so_far
);
    localparam int CW   = eic_pkg::COEF_W;
    localparam int CFW  = eic_pkg::CFG_W;
    localparam int TW   = eic_pkg::THRESH_W;
    localparam int PW   = eic_pkg::COORD_W;
    localparam int NW   = eic_pkg::COUNT_WIDTH;
    localparam int OCW  = eic_pkg::OUT_CNT_W;

    // Configuration registers
    logic [CFW-1:0] pair0_reg, pair1_reg, pair2_reg, pair3_reg;
    logic [CW-1:0]  coef_last_reg;
    logic [TW-1:0]  thresh_reg;
    logic [eic_pkg::NUM_COEF-1:0][CW-1:0] coef;

    // Captured match
    logic [PW-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic           set_start_reg;

    // Tally and output register
    logic [NW-1:0]  tally_reg, tally_base, tally_next;
    logic [31:0]    tally_wide;
    logic           m_valid_reg;
    logic           m_inlier_reg;
    logic [OCW-1:0] m_count_reg;

    logic           accept, out_free, ready, load, inl;
    logic           ok1, ok2;
    logic [eic_pkg::LIMB_W-1:0] opa, opb;
    logic           prod_neg;
    logic [eic_pkg::ACC_W-1:0]  acc;
    eic_pkg::ctrl_t ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair0_reg     <= '0;
            pair1_reg     <= '0;
            pair2_reg     <= '0;
            pair3_reg     <= '0;
            coef_last_reg <= '0;
            thresh_reg    <= eic_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            unique case (eic_pkg::cfg_reg_t'(cfg_addr))
                eic_pkg::CFG_PAIR0:  pair0_reg     <= cfg_wdata;
                eic_pkg::CFG_PAIR1:  pair1_reg     <= cfg_wdata;
                eic_pkg::CFG_PAIR2:  pair2_reg     <= cfg_wdata;
                eic_pkg::CFG_PAIR3:  pair3_reg     <= cfg_wdata;
                eic_pkg::CFG_LAST:   coef_last_reg <= cfg_wdata[CW-1:0];
                eic_pkg::CFG_THRESH: thresh_reg    <= cfg_wdata[TW-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // F in row-major order, low half of each pair first
    assign coef[0] = pair0_reg[CW-1:0];
    assign coef[1] = pair0_reg[2*CW-1:CW];
    assign coef[2] = pair1_reg[CW-1:0];
    assign coef[3] = pair1_reg[2*CW-1:CW];
    assign coef[4] = pair2_reg[CW-1:0];
    assign coef[5] = pair2_reg[2*CW-1:CW];
    assign coef[6] = pair3_reg[CW-1:0];
    assign coef[7] = pair3_reg[2*CW-1:CW];
    assign coef[8] = coef_last_reg;

    assign accept   = s_valid && s_ready;
    assign s_ready  = ready;
    assign out_free = !m_valid_reg || m_ready;

    // match is held for the whole schedule; no new transaction until idle
    always_ff @(posedge aclk) begin
        if (accept) begin
            x1_reg        <= s_x_first;
            y1_reg        <= s_y_first;
            x2_reg        <= s_x_second;
            y2_reg        <= s_y_second;
            set_start_reg <= s_set_start;
        end
    end

    eic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .out_free (out_free),
        .ready    (ready),
        .load     (load),
        .ctrl_o   (ctrl)
    );

    eic_opnd u_opnd (
        .aclk     (aclk),
        .ctrl_i   (ctrl),
        .acc      (acc),
        .coef     (coef),
        .thresh   (thresh_reg),
        .x1       (x1_reg),
        .y1       (y1_reg),
        .x2       (x2_reg),
        .y2       (y2_reg),
        .opa      (opa),
        .opb      (opb),
        .prod_neg (prod_neg),
        .ok1      (ok1),
        .ok2      (ok2)
    );

    eic_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_i   (ctrl),
        .opa      (opa),
        .opb      (opb),
        .prod_neg (prod_neg),
        .acc      (acc)
    );

    // both lines must pass: r^2 <= T * 2^(2*frac) * (a^2 + b^2)
    assign inl = ok1 && ok2;

    // set_start clears before counting; tally holds once full
    always_comb begin
        tally_base = set_start_reg ? '0 : tally_reg;
        tally_next = (inl && tally_base != '1) ? NW'(tally_base + 1'b1) : tally_base;
        tally_wide = 32'(tally_next);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_inlier_reg <= inl;
            m_count_reg  <= tally_wide[OCW-1:0];
        end
        if (!aresetn) begin
            tally_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) tally_reg <= tally_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_is_inlier      = m_inlier_reg;
    assign m_inliers_so_far = m_count_reg;

endmodule
